[rtl/sphere_volume_classifier_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sphere volume classifier
// Concurrent assertion wrappers that compile to nothing under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SPHERE_VOLUME_CLASSIFIER_CORE_MACROS_SVH
`define SPHERE_VOLUME_CLASSIFIER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every rising clock edge outside reset.
`define SVC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sphere volume classifier assertion failed");
// The expression must never be true at a rising clock edge outside reset.
`define SVC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sphere volume classifier forbidden condition seen");
`else
`define SVC_ASSERT(lbl, clk, rst, prop)
`define SVC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

[rtl/svc_pkg.sv]
// ----------------------------------------------------------------------------
// Sphere volume classifier package
// Shared constants, query and verdict codes and the stage flag struct.
// ----------------------------------------------------------------------------
`default_nettype none

package svc_pkg;

   localparam int unsigned COORD_BITS_DEFAULT = 32;
   localparam int unsigned AXIS_COUNT         = 3;
   localparam int unsigned CORNER_COUNT       = 8;
   localparam int unsigned KIND_BITS          = 2;
   localparam int unsigned VERDICT_BITS       = 2;
   localparam int unsigned CSR_INDEX_BITS     = 2;

   // Query kinds.
   localparam logic [KIND_BITS-1:0] KIND_POINT  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SPHERE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BOX    = 2'd2;

   // Verdict codes.
   localparam logic [VERDICT_BITS-1:0] VERDICT_OUTSIDE      = 2'd0;
   localparam logic [VERDICT_BITS-1:0] VERDICT_INTERMEDIATE = 2'd1;
   localparam logic [VERDICT_BITS-1:0] VERDICT_INSIDE       = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Z    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_RADIUS = 2'd3;

   // Per-item status that travels down the pipeline with the data.
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 cube_miss;
      logic                 qr_fits;
   } flags_type;

endpackage

`default_nettype wire

[rtl/svc_channel_if.sv]
// ----------------------------------------------------------------------------
// Sphere volume classifier channels
// Query and verdict channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface svc_req_if #(
   parameter int unsigned COORD_BITS = svc_pkg::COORD_BITS_DEFAULT
);
   logic                               valid;
   logic                               ready;
   logic [svc_pkg::KIND_BITS-1:0]      req_type;
   logic signed [COORD_BITS-1:0]       ax;
   logic signed [COORD_BITS-1:0]       ay;
   logic signed [COORD_BITS-1:0]       az;
   logic signed [COORD_BITS-1:0]       bx;
   logic signed [COORD_BITS-1:0]       by;
   logic signed [COORD_BITS-1:0]       bz;
   logic [COORD_BITS-2:0]              query_radius;

   modport source (
      output valid, req_type, ax, ay, az, bx, by, bz, query_radius,
      input  ready
   );
   modport sink (
      input  valid, req_type, ax, ay, az, bx, by, bz, query_radius,
      output ready
   );
endinterface

interface svc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [svc_pkg::VERDICT_BITS-1:0] verdict;

   modport source (
      output valid, verdict,
      input  ready
   );
   modport sink (
      input  valid, verdict,
      output ready
   );
endinterface

`default_nettype wire

[rtl/svc_delta.sv]
// ----------------------------------------------------------------------------
// Classifier stage 1: offsets and bounding cube test
// Takes a query item, forms absolute offsets from the sphere center for
// both box corners, the radius sum and difference, and the cube overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_delta #(
   parameter int unsigned COORD_BITS = svc_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   svc_req_if.sink                               req,
   input  wire logic signed [COORD_BITS-1:0]     center_x,
   input  wire logic signed [COORD_BITS-1:0]     center_y,
   input  wire logic signed [COORD_BITS-1:0]     center_z,
   input  wire logic [COORD_BITS-2:0]            clip_radius,
   output logic                                  out_valid,
   input  wire                                   out_ready,
   output logic [2:0][COORD_BITS-1:0]            dist_lo,
   output logic [2:0][COORD_BITS-1:0]            dist_hi,
   output logic [COORD_BITS-1:0]                 rsum,
   output logic [COORD_BITS-2:0]                 rdiff,
   output svc_pkg::flags_type                    flags
);
   import svc_pkg::*;

   function automatic logic [COORD_BITS-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic [COORD_BITS:0] d;
      logic [COORD_BITS:0] m;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      m = d[COORD_BITS] ? (~d + 1'b1) : d;
      // The magnitude of a difference of two coordinates fits the coordinate width.
      return m[COORD_BITS-1:0];
   endfunction

   logic                          valid_ff;
   logic                          valid_in;
   logic                          load;
   logic [2:0][COORD_BITS-1:0]    dist_lo_ff, dist_lo_in;
   logic [2:0][COORD_BITS-1:0]    dist_hi_ff, dist_hi_in;
   logic [COORD_BITS-1:0]         rsum_ff, rsum_in;
   logic [COORD_BITS-2:0]         rdiff_ff, rdiff_in;
   flags_type                     flags_ff, flags_in;

   logic signed [COORD_BITS-1:0]  lo_c [AXIS_COUNT];
   logic signed [COORD_BITS-1:0]  hi_c [AXIS_COUNT];
   logic signed [COORD_BITS-1:0]  ctr  [AXIS_COUNT];
   logic signed [COORD_BITS:0]    r_ext;
   logic signed [COORD_BITS:0]    c_ext;
   logic signed [COORD_BITS:0]    upper;
   logic signed [COORD_BITS:0]    lower;
   logic [AXIS_COUNT-1:0]         axis_miss;

   assign req.ready = !valid_ff || out_ready;
   assign load      = req.valid && req.ready;
   assign valid_in  = req.ready ? req.valid : valid_ff;

   always_comb begin
      lo_c[0] = req.ax;
      lo_c[1] = req.ay;
      lo_c[2] = req.az;
      hi_c[0] = req.bx;
      hi_c[1] = req.by;
      hi_c[2] = req.bz;
      ctr[0]  = center_x;
      ctr[1]  = center_y;
      ctr[2]  = center_z;
      r_ext   = {2'b00, clip_radius};
      c_ext   = '0;
      upper   = '0;
      lower   = '0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         dist_lo_in[i] = abs_diff(lo_c[i], ctr[i]);
         dist_hi_in[i] = abs_diff(hi_c[i], ctr[i]);
         c_ext         = {ctr[i][COORD_BITS-1], ctr[i]};
         upper         = c_ext + r_ext;
         lower         = c_ext - r_ext;
         axis_miss[i]  = (upper < $signed({lo_c[i][COORD_BITS-1], lo_c[i]})) ||
                         (lower > $signed({hi_c[i][COORD_BITS-1], hi_c[i]}));
      end
      rsum_in            = {1'b0, clip_radius} + {1'b0, req.query_radius};
      flags_in.kind      = req.req_type;
      flags_in.cube_miss = |axis_miss;
      flags_in.qr_fits   = (req.query_radius <= clip_radius);
      rdiff_in           = flags_in.qr_fits ? (clip_radius - req.query_radius) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dist_lo_ff <= dist_lo_in;
         dist_hi_ff <= dist_hi_in;
         rsum_ff    <= rsum_in;
         rdiff_ff   <= rdiff_in;
         flags_ff   <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign dist_lo   = dist_lo_ff;
   assign dist_hi   = dist_hi_ff;
   assign rsum      = rsum_ff;
   assign rdiff     = rdiff_ff;
   assign flags     = flags_ff;

endmodule

`default_nettype wire

[rtl/svc_square.sv]
// ----------------------------------------------------------------------------
// Classifier stage 2: squares
// Squares the six axis offsets and the three radius terms in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_square #(
   parameter int unsigned COORD_BITS = svc_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  wire logic [2:0][COORD_BITS-1:0]     dist_lo,
   input  wire logic [2:0][COORD_BITS-1:0]     dist_hi,
   input  wire logic [COORD_BITS-1:0]          rsum,
   input  wire logic [COORD_BITS-2:0]          rdiff,
   input  wire logic [COORD_BITS-2:0]          clip_radius,
   input  wire svc_pkg::flags_type             flags_up,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output logic [2:0][2*COORD_BITS-1:0]        sq_lo,
   output logic [2:0][2*COORD_BITS-1:0]        sq_hi,
   output logic [2*COORD_BITS-1:0]             rsum2,
   output logic [2*COORD_BITS-3:0]             rdiff2,
   output logic [2*COORD_BITS-3:0]             rr2,
   output svc_pkg::flags_type                  flags_dn
);
   import svc_pkg::*;

   function automatic logic [2*COORD_BITS-1:0] square(input logic [COORD_BITS-1:0] v);
      logic [2*COORD_BITS-1:0] e;
      e = {{COORD_BITS{1'b0}}, v};
      return e * e;
   endfunction

   function automatic logic [2*COORD_BITS-3:0] square_r(input logic [COORD_BITS-2:0] v);
      logic [2*COORD_BITS-3:0] e;
      e = {{(COORD_BITS-1){1'b0}}, v};
      return e * e;
   endfunction

   logic                             valid_ff;
   logic                             valid_in;
   logic                             load;
   logic [2:0][2*COORD_BITS-1:0]     sq_lo_ff, sq_lo_in;
   logic [2:0][2*COORD_BITS-1:0]     sq_hi_ff, sq_hi_in;
   logic [2*COORD_BITS-1:0]          rsum2_ff, rsum2_in;
   logic [2*COORD_BITS-3:0]          rdiff2_ff, rdiff2_in;
   logic [2*COORD_BITS-3:0]          rr2_ff, rr2_in;
   flags_type                        flags_ff;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         sq_lo_in[i] = square(dist_lo[i]);
         sq_hi_in[i] = square(dist_hi[i]);
      end
      rsum2_in  = square(rsum);
      rdiff2_in = square_r(rdiff);
      rr2_in    = square_r(clip_radius);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_lo_ff  <= sq_lo_in;
         sq_hi_ff  <= sq_hi_in;
         rsum2_ff  <= rsum2_in;
         rdiff2_ff <= rdiff2_in;
         rr2_ff    <= rr2_in;
         flags_ff  <= flags_up;
      end
   end

   assign out_valid = valid_ff;
   assign sq_lo     = sq_lo_ff;
   assign sq_hi     = sq_hi_ff;
   assign rsum2     = rsum2_ff;
   assign rdiff2    = rdiff2_ff;
   assign rr2       = rr2_ff;
   assign flags_dn  = flags_ff;

endmodule

`default_nettype wire

[rtl/svc_accum.sv]
// ----------------------------------------------------------------------------
// Classifier stages 3 and 4: corner distance sums
// Adds the squared offsets into the squared distance of each of the eight
// box corners: x plus y in the first stage, z in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_accum #(
   parameter int unsigned COORD_BITS = svc_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  wire logic [2:0][2*COORD_BITS-1:0]   sq_lo,
   input  wire logic [2:0][2*COORD_BITS-1:0]   sq_hi,
   input  wire logic [2*COORD_BITS-1:0]        rsum2_up,
   input  wire logic [2*COORD_BITS-3:0]        rdiff2_up,
   input  wire logic [2*COORD_BITS-3:0]        rr2_up,
   input  wire svc_pkg::flags_type             flags_up,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output logic [7:0][2*COORD_BITS+1:0]        dist2,
   output logic [2*COORD_BITS-1:0]             rsum2_dn,
   output logic [2*COORD_BITS-3:0]             rdiff2_dn,
   output logic [2*COORD_BITS-3:0]             rr2_dn,
   output svc_pkg::flags_type                  flags_dn
);
   import svc_pkg::*;

   localparam int unsigned SQ_BITS  = 2 * COORD_BITS;
   localparam int unsigned XY_COUNT = CORNER_COUNT / 2;

   // First stage: the four x/y pairings. Index bit 0 picks the x end, bit 1 the y end.
   logic                              xy_valid_ff;
   logic                              xy_valid_in;
   logic                              xy_ready;
   logic                              xy_load;
   logic [XY_COUNT-1:0][SQ_BITS:0]    xy_ff, xy_in;
   logic [1:0][SQ_BITS-1:0]           sqz_ff;
   logic [SQ_BITS-1:0]                rsum2_a_ff;
   logic [SQ_BITS-3:0]                rdiff2_a_ff;
   logic [SQ_BITS-3:0]                rr2_a_ff;
   flags_type                         flags_a_ff;

   // Second stage: full corner distances. Index bit 2 picks the z end.
   logic                                  d_valid_ff;
   logic                                  d_valid_in;
   logic                                  d_load;
   logic [CORNER_COUNT-1:0][SQ_BITS+1:0]  d_ff, d_in;
   logic [SQ_BITS-1:0]                    rsum2_b_ff;
   logic [SQ_BITS-3:0]                    rdiff2_b_ff;
   logic [SQ_BITS-3:0]                    rr2_b_ff;
   flags_type                             flags_b_ff;

   assign xy_ready    = !d_valid_ff || out_ready;
   assign in_ready    = !xy_valid_ff || xy_ready;
   assign xy_load     = in_valid && in_ready;
   assign xy_valid_in = in_ready ? in_valid : xy_valid_ff;
   assign d_load      = xy_valid_ff && xy_ready;
   assign d_valid_in  = xy_ready ? xy_valid_ff : d_valid_ff;

   always_comb begin
      for (int j = 0; j < XY_COUNT; j++) begin
         xy_in[j] = {1'b0, (j[0] ? sq_hi[0] : sq_lo[0])} +
                    {1'b0, (j[1] ? sq_hi[1] : sq_lo[1])};
      end
      for (int k = 0; k < CORNER_COUNT; k++) begin
         d_in[k] = {1'b0, xy_ff[k[1:0]]} + {2'b00, sqz_ff[k[2]]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xy_valid_ff <= 1'b0;
         d_valid_ff  <= 1'b0;
      end else begin
         xy_valid_ff <= xy_valid_in;
         d_valid_ff  <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xy_load) begin
         xy_ff       <= xy_in;
         sqz_ff[0]   <= sq_lo[2];
         sqz_ff[1]   <= sq_hi[2];
         rsum2_a_ff  <= rsum2_up;
         rdiff2_a_ff <= rdiff2_up;
         rr2_a_ff    <= rr2_up;
         flags_a_ff  <= flags_up;
      end
      if (d_load) begin
         d_ff        <= d_in;
         rsum2_b_ff  <= rsum2_a_ff;
         rdiff2_b_ff <= rdiff2_a_ff;
         rr2_b_ff    <= rr2_a_ff;
         flags_b_ff  <= flags_a_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign dist2     = d_ff;
   assign rsum2_dn  = rsum2_b_ff;
   assign rdiff2_dn = rdiff2_b_ff;
   assign rr2_dn    = rr2_b_ff;
   assign flags_dn  = flags_b_ff;

endmodule

`default_nettype wire

[rtl/svc_judge.sv]
// ----------------------------------------------------------------------------
// Classifier stage 5: verdict
// Compares the squared distances with the radius terms, picks the verdict
// for the query kind and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_judge #(
   parameter int unsigned COORD_BITS = svc_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  wire logic [7:0][2*COORD_BITS+1:0]   dist2,
   input  wire logic [2*COORD_BITS-1:0]        rsum2,
   input  wire logic [2*COORD_BITS-3:0]        rdiff2,
   input  wire logic [2*COORD_BITS-3:0]        rr2,
   input  wire svc_pkg::flags_type             flags,
   svc_rsp_if.source                           rsp
);
   import svc_pkg::*;

   localparam int unsigned D_BITS = 2 * COORD_BITS + 2;

   logic                        valid_ff;
   logic                        valid_in;
   logic                        load;
   logic [VERDICT_BITS-1:0]     verdict_ff;
   logic [VERDICT_BITS-1:0]     verdict_in;
   logic [D_BITS-1:0]           rr2_ext;
   logic [D_BITS-1:0]           rsum2_ext;
   logic [D_BITS-1:0]           rdiff2_ext;
   logic [CORNER_COUNT-1:0]     corner_out;

   assign in_ready = !valid_ff || rsp.ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      rr2_ext    = {4'b0000, rr2};
      rsum2_ext  = {2'b00, rsum2};
      rdiff2_ext = {4'b0000, rdiff2};
      for (int k = 0; k < CORNER_COUNT; k++) begin
         corner_out[k] = dist2[k] > rr2_ext;
      end
      // Corner zero is the point itself, or the query sphere's center.
      case (flags.kind)
         KIND_POINT: begin
            verdict_in = corner_out[0] ? VERDICT_OUTSIDE : VERDICT_INSIDE;
         end
         KIND_SPHERE: begin
            if (dist2[0] > rsum2_ext) begin
               verdict_in = VERDICT_OUTSIDE;
            end else if (flags.qr_fits && (dist2[0] <= rdiff2_ext)) begin
               verdict_in = VERDICT_INSIDE;
            end else begin
               verdict_in = VERDICT_INTERMEDIATE;
            end
         end
         KIND_BOX: begin
            if (flags.cube_miss) begin
               verdict_in = VERDICT_OUTSIDE;
            end else if (|corner_out) begin
               verdict_in = VERDICT_INTERMEDIATE;
            end else begin
               verdict_in = VERDICT_INSIDE;
            end
         end
         default: begin
            verdict_in = VERDICT_OUTSIDE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp.valid   = valid_ff;
   assign rsp.verdict = verdict_ff;

endmodule

`default_nettype wire

[rtl/sphere_volume_classifier_core.sv]
// Five register stages, each with its own valid bit, carry a query from acceptance to its verdict.
// Throughput: one query per cycle while the output is not stalled.
// Stages: offsets and cube test, squares, x/y sums, z sums, compare and output register.
// A stalled output backs up stage by stage, so empty stages still take new queries.
// Reset (synchronous, active high) clears all valid bits and the sphere registers.
// ----------------------------------------------------------------------------
// Sphere volume classifier core
// Classifies point, sphere and box queries against a configured clip sphere.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_volume_classifier_core_macros.svh"

module sphere_volume_classifier_core #(
   parameter int unsigned COORD_BITS = svc_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                       clock,
   input  wire                                       reset,
   svc_req_if.sink                                   req_ch,
   svc_rsp_if.source                                 rsp_ch,
   input  wire                                       csr_we,
   input  wire logic [svc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [COORD_BITS-1:0]                csr_wdata
);
   import svc_pkg::*;

   logic signed [COORD_BITS-1:0]   center_x_ff, center_x_in;
   logic signed [COORD_BITS-1:0]   center_y_ff, center_y_in;
   logic signed [COORD_BITS-1:0]   center_z_ff, center_z_in;
   logic [COORD_BITS-2:0]          clip_radius_ff, clip_radius_in;

   logic                           d_valid, d_ready;
   logic [2:0][COORD_BITS-1:0]     d_dist_lo, d_dist_hi;
   logic [COORD_BITS-1:0]          d_rsum;
   logic [COORD_BITS-2:0]          d_rdiff;
   flags_type                      d_flags;

   logic                           q_valid, q_ready;
   logic [2:0][2*COORD_BITS-1:0]   q_sq_lo, q_sq_hi;
   logic [2*COORD_BITS-1:0]        q_rsum2;
   logic [2*COORD_BITS-3:0]        q_rdiff2, q_rr2;
   flags_type                      q_flags;

   logic                           a_valid, a_ready;
   logic [7:0][2*COORD_BITS+1:0]   a_dist2;
   logic [2*COORD_BITS-1:0]        a_rsum2;
   logic [2*COORD_BITS-3:0]        a_rdiff2, a_rr2;
   flags_type                      a_flags;

   // Sphere registers; the user must write them only while no item is in flight, the block does not enforce it.
   always_comb begin
      center_x_in    = center_x_ff;
      center_y_in    = center_y_ff;
      center_z_in    = center_z_ff;
      clip_radius_in = clip_radius_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:    center_x_in    = csr_wdata;
            CSR_CENTER_Y:    center_y_in    = csr_wdata;
            CSR_CENTER_Z:    center_z_in    = csr_wdata;
            CSR_CLIP_RADIUS: clip_radius_in = csr_wdata[COORD_BITS-2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         center_z_ff    <= '0;
         clip_radius_ff <= '0;
      end else begin
         center_x_ff    <= center_x_in;
         center_y_ff    <= center_y_in;
         center_z_ff    <= center_z_in;
         clip_radius_ff <= clip_radius_in;
      end
   end

   svc_delta #(.COORD_BITS(COORD_BITS)) u_delta (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .center_z    (center_z_ff),
      .clip_radius (clip_radius_ff),
      .out_valid   (d_valid),
      .out_ready   (d_ready),
      .dist_lo     (d_dist_lo),
      .dist_hi     (d_dist_hi),
      .rsum        (d_rsum),
      .rdiff       (d_rdiff),
      .flags       (d_flags)
   );

   svc_square #(.COORD_BITS(COORD_BITS)) u_square (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_ready    (d_ready),
      .dist_lo     (d_dist_lo),
      .dist_hi     (d_dist_hi),
      .rsum        (d_rsum),
      .rdiff       (d_rdiff),
      .clip_radius (clip_radius_ff),
      .flags_up    (d_flags),
      .out_valid   (q_valid),
      .out_ready   (q_ready),
      .sq_lo       (q_sq_lo),
      .sq_hi       (q_sq_hi),
      .rsum2       (q_rsum2),
      .rdiff2      (q_rdiff2),
      .rr2         (q_rr2),
      .flags_dn    (q_flags)
   );

   svc_accum #(.COORD_BITS(COORD_BITS)) u_accum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .sq_lo       (q_sq_lo),
      .sq_hi       (q_sq_hi),
      .rsum2_up    (q_rsum2),
      .rdiff2_up   (q_rdiff2),
      .rr2_up      (q_rr2),
      .flags_up    (q_flags),
      .out_valid   (a_valid),
      .out_ready   (a_ready),
      .dist2       (a_dist2),
      .rsum2_dn    (a_rsum2),
      .rdiff2_dn   (a_rdiff2),
      .rr2_dn      (a_rr2),
      .flags_dn    (a_flags)
   );

   svc_judge #(.COORD_BITS(COORD_BITS)) u_judge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (a_valid),
      .in_ready    (a_ready),
      .dist2       (a_dist2),
      .rsum2       (a_rsum2),
      .rdiff2      (a_rdiff2),
      .rr2         (a_rr2),
      .flags       (a_flags),
      .rsp         (rsp_ch)
   );

   // With the output register empty, every stage can advance, so a query is always taken.
   `SVC_ASSERT(a_drain_ready, clock, reset, !rsp_ch.valid |-> req_ch.ready)
   // An item in the last summing stage moves into the output register when the sink takes.
   `SVC_ASSERT(a_tail_moves, clock, reset, (a_valid && rsp_ch.ready) |=> rsp_ch.valid)
   // The first stage must not take a new query while it holds an item it cannot pass on.
   `SVC_ASSERT_NEVER(a_head_overrun, clock, reset, d_valid && !d_ready && req_ch.ready)

endmodule

`default_nettype wire

[test/svc_verdict_checker.sv]
// ----------------------------------------------------------------------------
// Sphere volume classifier verdict checker
// Watches the query, verdict and register ports, works out the verdict of
// every accepted query with exact wide arithmetic and compares it in order
// with the verdicts that leave the block.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_verdict_checker (
   input  wire                                         clock,
   input  wire                                         reset,
   svc_req_if                                          req_mon,
   svc_rsp_if                                          rsp_mon,
   input  wire                                         csr_we,
   input  wire logic [svc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [svc_pkg::COORD_BITS_DEFAULT-1:0] csr_wdata,
   output int                                          fail_count,
   output int                                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import svc_pkg::*;

   // Clip sphere as the block should hold it.
   longint                    sphere_ctr [AXIS_COUNT];
   longint                    sphere_rad;

   logic [VERDICT_BITS-1:0]   verdict_queue [$];
   logic [VERDICT_BITS-1:0]   want;
   longint                    q_lo [AXIS_COUNT];
   longint                    q_hi [AXIS_COUNT];
   longint                    q_rad;

   function automatic logic [127:0] square_wide(input longint unsigned mag);
      logic [127:0] w;
      w = {64'd0, mag};
      return w * w;
   endfunction

   function automatic longint unsigned abs_gap(input longint a, input longint b);
      longint d;
      d = a - b;
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic [127:0] center_dist_sq(input longint x, input longint y,
                                                   input longint z);
      return square_wide(abs_gap(x, sphere_ctr[0])) + square_wide(abs_gap(y, sphere_ctr[1]))
           + square_wide(abs_gap(z, sphere_ctr[2]));
   endfunction

   function automatic bit point_in_sphere(input longint x, input longint y, input longint z);
      return center_dist_sq(x, y, z) <= square_wide(sphere_rad);
   endfunction

   function automatic logic [VERDICT_BITS-1:0] sphere_query_verdict(input longint lo [AXIS_COUNT],
                                                                   input longint rad);
      logic [127:0] d2;
      d2 = center_dist_sq(lo[0], lo[1], lo[2]);
      if (d2 > square_wide(sphere_rad + rad))
         return VERDICT_OUTSIDE;
      // The inner bound only exists when the query sphere fits inside the clip sphere.
      if (rad <= sphere_rad && d2 <= square_wide(sphere_rad - rad))
         return VERDICT_INSIDE;
      return VERDICT_INTERMEDIATE;
   endfunction

   function automatic logic [VERDICT_BITS-1:0] box_query_verdict(input longint lo [AXIS_COUNT],
                                                                input longint hi [AXIS_COUNT]);
      longint cx, cy, cz;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (sphere_ctr[a] + sphere_rad < lo[a] || sphere_ctr[a] - sphere_rad > hi[a])
            return VERDICT_OUTSIDE;
      end
      // Corners are taken exactly as given, so a reversed box is not reordered.
      for (int i = 0; i < CORNER_COUNT; i++) begin
         cx = i[0] ? hi[0] : lo[0];
         cy = i[1] ? hi[1] : lo[1];
         cz = i[2] ? hi[2] : lo[2];
         if (!point_in_sphere(cx, cy, cz))
            return VERDICT_INTERMEDIATE;
      end
      return VERDICT_INSIDE;
   endfunction

   function automatic logic [VERDICT_BITS-1:0] query_verdict(input logic [KIND_BITS-1:0] kind,
                                                            input longint lo [AXIS_COUNT],
                                                            input longint hi [AXIS_COUNT],
                                                            input longint rad);
      case (kind)
         KIND_POINT:  return point_in_sphere(lo[0], lo[1], lo[2]) ? VERDICT_INSIDE
                                                                  : VERDICT_OUTSIDE;
         KIND_SPHERE: return sphere_query_verdict(lo, rad);
         KIND_BOX:    return box_query_verdict(lo, hi);
         default:     return VERDICT_OUTSIDE;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXIS_COUNT; a++)
            sphere_ctr[a] = 0;
         sphere_rad = 0;
         verdict_queue.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         // An item accepted at this edge still sees the old registers.
         if (req_mon.valid && req_mon.ready) begin
            q_lo[0] = req_mon.ax;
            q_lo[1] = req_mon.ay;
            q_lo[2] = req_mon.az;
            q_hi[0] = req_mon.bx;
            q_hi[1] = req_mon.by;
            q_hi[2] = req_mon.bz;
            q_rad   = req_mon.query_radius;
            verdict_queue.push_back(query_verdict(req_mon.req_type, q_lo, q_hi, q_rad));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CENTER_X:    sphere_ctr[0] = $signed(csr_wdata);
               CSR_CENTER_Y:    sphere_ctr[1] = $signed(csr_wdata);
               CSR_CENTER_Z:    sphere_ctr[2] = $signed(csr_wdata);
               CSR_CLIP_RADIUS: sphere_rad = csr_wdata[COORD_BITS_DEFAULT-2:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected verdict, expected none actual %0d",
                        $realtime, rsp_mon.verdict);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (want !== rsp_mon.verdict) begin
                  $display("%0t: verdict mismatch, expected %0d actual %0d",
                           $realtime, want, rsp_mon.verdict);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= verdict_queue.size();
      end
   end

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Sphere volume classifier testbench
// Drives directed and random point, sphere and box queries through a series
// of clip sphere settings, with random gaps on the query side and random
// stalls on the verdict side; the checker beside the block scores the run.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import svc_pkg::*;

   localparam int CB             = COORD_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 103;

   typedef struct {
      logic [KIND_BITS-1:0] kind;
      logic signed [CB-1:0] lo [AXIS_COUNT];
      logic signed [CB-1:0] hi [AXIS_COUNT];
      logic [CB-2:0]        rad;
   } query_type;

   localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic [CB-2:0]        R_MAX = {(CB-1){1'b1}};

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CB-1:0]       csr_wdata;
   int                  fail_count;
   int                  pending_count;
   int                  idle_cycles;
   bit                  calm;

   // Current clip sphere, used only to aim random queries.
   longint              aim_ctr [AXIS_COUNT];
   longint              aim_rad;

   svc_req_if #(.COORD_BITS(CB)) req_ch ();
   svc_rsp_if                    rsp_ch ();

   sphere_volume_classifier_core #(.COORD_BITS(CB)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   svc_verdict_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly no gap, some short ones and now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 98)
         return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic longint rand_upto(input longint top);
      longint unsigned raw;
      raw = {$urandom, $urandom};
      return longint'(raw % longint'(top + 1));
   endfunction

   function automatic logic signed [CB-1:0] near(input longint c, input longint span);
      return CB'(c + rand_upto(2 * span) - span);
   endfunction

   function automatic query_type make_query(input logic [KIND_BITS-1:0] kind,
                                            input logic signed [CB-1:0] lx, ly, lz, hx, hy, hz,
                                            input logic [CB-2:0] rad);
      query_type q;
      q.kind  = kind;
      q.lo[0] = lx;
      q.lo[1] = ly;
      q.lo[2] = lz;
      q.hi[0] = hx;
      q.hi[1] = hy;
      q.hi[2] = hz;
      q.rad   = rad;
      return q;
   endfunction

   function automatic query_type random_query();
      query_type q;
      longint span, ext, mid;
      logic signed [CB-1:0] tmp;
      int unsigned axis;
      bit tight;
      q = make_query(KIND_BITS'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, (CB-1)'($urandom));
      // A tenth of the items are plain noise over every field.
      if ($urandom_range(0, 9) == 0)
         return q;
      span = aim_rad + aim_rad / 2 + 1;
      q.kind = KIND_BITS'($urandom_range(0, 2));
      case (q.kind)
         KIND_POINT: begin
            for (int a = 0; a < AXIS_COUNT; a++)
               q.lo[a] = near(aim_ctr[a], span);
            if ($urandom_range(0, 7) == 0) begin
               // Exactly on the surface along one axis.
               for (int a = 0; a < AXIS_COUNT; a++)
                  q.lo[a] = CB'(aim_ctr[a]);
               axis = $urandom_range(0, 2);
               q.lo[axis] = CB'(aim_ctr[axis] + ($urandom_range(0, 1) ? aim_rad : -aim_rad));
            end
         end
         KIND_SPHERE: begin
            for (int a = 0; a < AXIS_COUNT; a++)
               q.lo[a] = near(aim_ctr[a], span);
            ext = ($urandom_range(0, 3) == 0) ? rand_upto(aim_rad / 8)
                                              : rand_upto(2 * aim_rad + 1);
            q.rad = (ext > longint'(R_MAX)) ? R_MAX : (CB-1)'(ext);
         end
         default: begin
            tight = ($urandom_range(0, 2) == 0);
            for (int a = 0; a < AXIS_COUNT; a++) begin
               mid = near(aim_ctr[a], tight ? aim_rad / 4 : span);
               ext = rand_upto(tight ? aim_rad / 3 : aim_rad);
               q.lo[a] = CB'(mid - ext);
               q.hi[a] = CB'(mid + ext);
            end
            if ($urandom_range(0, 9) == 0) begin
               axis = $urandom_range(0, 2);
               tmp = q.lo[axis];
               q.lo[axis] = q.hi[axis];
               q.hi[axis] = tmp;
            end
         end
      endcase
      return q;
   endfunction

   task automatic send_query(input query_type q);
      int unsigned gap;
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= q.kind;
      req_ch.ax           <= q.lo[0];
      req_ch.ay           <= q.lo[1];
      req_ch.az           <= q.lo[2];
      req_ch.bx           <= q.hi[0];
      req_ch.by           <= q.hi[1];
      req_ch.bz           <= q.hi[2];
      req_ch.query_radius <= q.rad;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every verdict is back and the pipeline has gone quiet.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure_sphere(input logic signed [CB-1:0] cx, cy, cz,
                                   input logic [CB-1:0] rad_word);
      aim_ctr[0] = cx;
      aim_ctr[1] = cy;
      aim_ctr[2] = cz;
      aim_rad    = rad_word[CB-2:0];
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= cx;
      @(posedge clock);
      csr_index <= CSR_CENTER_Y;
      csr_wdata <= cy;
      @(posedge clock);
      csr_index <= CSR_CENTER_Z;
      csr_wdata <= cz;
      @(posedge clock);
      csr_index <= CSR_CLIP_RADIUS;
      csr_wdata <= rad_word;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Verdict side: bursts of ready broken by random stalls.
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic signed [CB-1:0] cx, cy, cz;
      logic [CB-1:0] rad_word;
      int unsigned band;
      calm                = 1'b0;
      aim_rad             = 0;
      for (int a = 0; a < AXIS_COUNT; a++)
         aim_ctr[a] = 0;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_CENTER_X;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= KIND_POINT;
      req_ch.ax           <= '0;
      req_ch.ay           <= '0;
      req_ch.az           <= '0;
      req_ch.bx           <= '0;
      req_ch.by           <= '0;
      req_ch.bz           <= '0;
      req_ch.query_radius <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sphere left at reset: center at the origin with zero radius.
      send_query(make_query(KIND_POINT, 0, 0, 0, $urandom, $urandom, $urandom,
                            (CB-1)'($urandom)));
      send_query(make_query(KIND_POINT, 1, 0, 0, 0, 0, 0, 0));
      send_query(make_query(KIND_SPHERE, 0, 0, 0, $urandom, $urandom, $urandom, 0));
      send_query(make_query(KIND_SPHERE, 1, 0, 0, 0, 0, 0, 1));
      send_query(make_query(KIND_BOX, 0, 0, 0, 0, 0, 0, (CB-1)'($urandom)));
      send_query(make_query(2'd3, 0, 0, 0, 0, 0, 0, 0));

      // Center at the most negative corner, largest radius, spare data bit set.
      configure_sphere(C_MIN, C_MIN, C_MIN, {1'b1, R_MAX});
      send_query(make_query(KIND_POINT, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
      send_query(make_query(KIND_POINT, C_MIN, C_MIN, C_MIN, 0, 0, 0, R_MAX));
      send_query(make_query(KIND_SPHERE, C_MAX, C_MAX, C_MAX, 0, 0, 0, R_MAX));
      send_query(make_query(KIND_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, R_MAX));
      send_query(make_query(KIND_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0));
      send_query(make_query(KIND_BOX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0));
      send_query(make_query(KIND_BOX, C_MIN, C_MIN, C_MIN, -1, -1, -1, 0));
      send_query(make_query(KIND_BOX, 0, C_MIN, C_MIN, 1, -1, -1, 0));

      // Center at the most positive corner, zero radius, spare data bit set.
      configure_sphere(C_MAX, C_MAX, C_MAX, {1'b1, {(CB-1){1'b0}}});
      send_query(make_query(KIND_POINT, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, R_MAX));
      send_query(make_query(KIND_SPHERE, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
      send_query(make_query(KIND_SPHERE, C_MAX - 5, C_MAX, C_MAX, 0, 0, 0, R_MAX));
      send_query(make_query(KIND_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, R_MAX));
      send_query(make_query(KIND_BOX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0));
      send_query(make_query(KIND_BOX, C_MAX - 1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0));
      send_query(make_query(2'd3, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, R_MAX));

      for (int p = 0; p < PHASES; p++) begin
         if ($urandom_range(0, 1)) begin
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
         end else begin
            cx = near(0, 1 << 30);
            cy = near(0, 1 << 30);
            cz = near(0, 1 << 30);
         end
         band = $urandom_range(0, 2);
         if (p == 0)
            rad_word = {1'($urandom), R_MAX};
         else if (p == 1)
            rad_word = {1'($urandom), {(CB-1){1'b0}}};
         else if (band == 0)
            rad_word = {1'($urandom), (CB-1)'($urandom_range(1, 1 << 16))};
         else if (band == 1)
            rad_word = {1'($urandom), (CB-1)'($urandom_range(1 << 16, 1 << 24))};
         else
            rad_word = {1'($urandom), (CB-1)'($urandom_range(1 << 24, 1 << 30))};
         configure_sphere(cx, cy, cz, rad_word);
         calm = (p % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_query(random_query());
      end
      calm = 1'b0;

      wait_drained();
      repeat (12) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
